/* sv/soil_moisture_valve_reporter_macros.svh */
// Assertion helpers for the soil moisture valve reporter.
`ifndef SOIL_MOISTURE_VALVE_REPORTER_MACROS_SVH
`define SOIL_MOISTURE_VALVE_REPORTER_MACROS_SVH
`ifndef ASSERT_OFF
`define SMVR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("smvr assertion failed");
`define SMVR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) \
    else $error("smvr assertion failed");
`else
`define SMVR_ASSERT(lbl, clk, rst_n, prop)
`define SMVR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* sv/smvr_pkg.sv */
`default_nettype none
package smvr_pkg;

  typedef struct packed {
    logic [9:0] temp_sample;
    logic [9:0] moisture_sample;
  } smvr_in_t;

  typedef struct packed {
    logic [7:0]  text_byte;
    logic        last_byte;
    logic        valve_open;
    logic [13:0] temperature_centi;
    logic [9:0]  moisture_tenths;
  } smvr_out_t;

  typedef struct packed {
    logic        control_enabled;
    logic        report_moisture;
    logic [6:0]  trigger_percent;
    logic [12:0] wet_offset_mv;
    logic [12:0] span_mv;
  } smvr_cfg_t;

  typedef enum logic [2:0] {
    CFG_CONTROL_ENABLED = 3'd0,
    CFG_REPORT_MOISTURE = 3'd1,
    CFG_TRIGGER_PERCENT = 3'd2,
    CFG_WET_OFFSET_MV   = 3'd3,
    CFG_SPAN_MV         = 3'd4
  } smvr_cfg_idx_t;

  localparam int unsigned CFG_DATA_W = 13;

  localparam logic        RST_CONTROL_ENABLED = 1'b1;
  localparam logic        RST_REPORT_MOISTURE = 1'b0;
  localparam logic [6:0]  RST_TRIGGER_PERCENT = 7'd10;
  localparam logic [12:0] RST_WET_OFFSET_MV   = 13'd1281;
  localparam logic [12:0] RST_SPAN_MV         = 13'd930;

  // report job handed from front to back
  typedef struct packed {
    logic [3:0][3:0] digits;
    logic            rep_moist;
    logic            valve;
    logic [13:0]     temp_centi;
    logic [9:0]      moist_tenths;
  } smvr_job_t;

  typedef struct packed {
    logic      valid;
    smvr_job_t job;
  } smvr_push_t;

  localparam logic [25:0] TEMP_SCALE  = 26'd50000;
  localparam logic [22:0] MOIST_SCALE = 23'd5000;
  localparam logic [22:0] ADC_FULL    = 23'd1023;
  localparam logic [22:0] CEIL_BIAS   = 23'd1022;
  localparam int unsigned DIV_SHIFT   = 36;
  localparam logic [26:0] RECIP_1023  = 27'((64'd1 << DIV_SHIFT) / 64'd1023);
  localparam int unsigned HUND_SHIFT  = 20;
  localparam logic [13:0] RECIP_100   = 14'((64'd1 << HUND_SHIFT) / 64'd100);

  localparam logic [13:0] TEMP_MAX    = 14'd9999;
  localparam logic [9:0]  MOIST_FULL  = 10'd1000;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_POINT = 8'h2E;
  localparam logic [7:0] ASCII_CR    = 8'h0D;
  localparam logic [7:0] ASCII_LF    = 8'h0A;

  localparam logic [2:0] POS_D3   = 3'd0;
  localparam logic [2:0] POS_D2   = 3'd1;
  localparam logic [2:0] POS_MIDA = 3'd2;
  localparam logic [2:0] POS_MIDB = 3'd3;
  localparam logic [2:0] POS_D0   = 3'd4;
  localparam logic [2:0] POS_CR   = 3'd5;
  localparam logic [2:0] POS_LF   = 3'd6;

  // exact for x up to 127
  function automatic logic [3:0] div10(input logic [6:0] x);
    logic [14:0] p;
    p = 15'(x) * 15'd205;
    return p[14:11];
  endfunction

  function automatic logic [3:0] mod10(input logic [6:0] x);
    logic [3:0] q;
    logic [6:0] t;
    q = div10(x);
    t = x - (7'({q, 3'b000}) + 7'({q, 1'b0}));
    return t[3:0];
  endfunction

endpackage
`default_nettype wire

/* sv/soil_moisture_valve_reporter.sv */
// Path: an accepted sample pair runs through the conversion pipeline into the job
// queue; the output stage then loads its report bytes one at a time into the output
// register, from which each byte can leave once it is loaded.
// Each pair gives seven report bytes, sent by the single byte-serial output stage.
// The 7-stage conversion pipeline and a 2-entry job queue absorb output stalls.
// Reset (rst_n low at a clock edge) empties the pipeline and queue and loads
// the configuration defaults.
`default_nettype none
module soil_moisture_valve_reporter import smvr_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire smvr_in_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output smvr_out_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  smvr_cfg_t  cfg_r;
  smvr_push_t push;
  smvr_job_t  head;
  logic       q_full, q_empty, pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.control_enabled <= RST_CONTROL_ENABLED;
      cfg_r.report_moisture <= RST_REPORT_MOISTURE;
      cfg_r.trigger_percent <= RST_TRIGGER_PERCENT;
      cfg_r.wet_offset_mv   <= RST_WET_OFFSET_MV;
      cfg_r.span_mv         <= RST_SPAN_MV;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CONTROL_ENABLED: cfg_r.control_enabled <= cfg_data[0];
        CFG_REPORT_MOISTURE: cfg_r.report_moisture <= cfg_data[0];
        CFG_TRIGGER_PERCENT: cfg_r.trigger_percent <= cfg_data[6:0];
        CFG_WET_OFFSET_MV:   cfg_r.wet_offset_mv   <= cfg_data[12:0];
        CFG_SPAN_MV:         cfg_r.span_mv         <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  smvr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .push     (push),
    .q_full   (q_full)
  );

  smvr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .pop   (pop),
    .head  (head),
    .empty (q_empty)
  );

  smvr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

/* sv/smvr_front.sv */
`default_nettype none
module smvr_front import smvr_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire smvr_in_t   in_data,
  input  wire smvr_cfg_t  cfg,
  output smvr_push_t      push,
  input  wire logic       q_full
);

  localparam int unsigned NST = 7;

  logic [NST-1:0] vld_r;
  logic           advance;

  // stage 1
  logic [25:0] s1_tprod_r;
  logic [22:0] s1_mprod_r, s1_wet_r;
  logic [13:0] s1_wsum_r;
  // stage 2
  logic [52:0] tmul;
  logic [49:0] mmul;
  logic [22:0] mx;
  logic [25:0] s2_tprod_r;
  logic [22:0] s2_mx_r;
  logic [15:0] s2_tq_r;
  logic [12:0] s2_mq_r;
  logic        s2_wet_r;
  logic [13:0] s2_wsum_r;
  // stage 3
  logic [25:0] trem;
  logic [22:0] mrem;
  logic [15:0] s3_tq_nxt, s3_tq_r;
  logic [12:0] s3_mq_nxt, s3_mq_r;
  logic        s3_wet_r;
  logic [13:0] s3_wsum_r;
  // stage 4
  logic signed [14:0] mdiff;
  logic [10:0] thresh;
  logic [13:0] s4_t_nxt, s4_t_r;
  logic [9:0]  s4_m_nxt, s4_m_r;
  logic        s4_valve_nxt, s4_valve_r;
  // stage 5
  logic [13:0] sel_v;
  logic [27:0] hmul;
  logic [13:0] s5_v_r, s5_t_r;
  logic [6:0]  s5_h_r;
  logic [9:0]  s5_m_r;
  logic        s5_valve_r, s5_rep_r;
  // stage 6
  logic [13:0] h100, vrem;
  logic [6:0]  s6_h_nxt, s6_h_r, s6_r_nxt, s6_r_r;
  logic [13:0] s6_t_r;
  logic [9:0]  s6_m_r;
  logic        s6_valve_r, s6_rep_r;
  // stage 7
  smvr_job_t   s7_job_r;

  assign advance  = !(vld_r[NST-1] && q_full);
  assign in_stall = !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (advance) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  always_comb begin
    tmul = 53'(s1_tprod_r) * 53'(RECIP_1023);
    mx   = s1_mprod_r + CEIL_BIAS;
    mmul = 50'(mx) * 50'(RECIP_1023);

    trem = s2_tprod_r - (26'({s2_tq_r, 10'b0}) - 26'(s2_tq_r));
    mrem = s2_mx_r - (23'({s2_mq_r, 10'b0}) - 23'(s2_mq_r));
    s3_tq_nxt = (trem >= 26'(ADC_FULL)) ? s2_tq_r + 16'd1 : s2_tq_r;
    s3_mq_nxt = (mrem >= ADC_FULL) ? s2_mq_r + 13'd1 : s2_mq_r;

    s4_t_nxt = (s3_tq_r > 16'(TEMP_MAX)) ? TEMP_MAX : s3_tq_r[13:0];
    mdiff = $signed({1'b0, s3_wsum_r}) - $signed({2'b00, s3_mq_r});
    priority if (s3_wet_r) begin
      s4_m_nxt = MOIST_FULL;
    end else if (mdiff < 15'sd0) begin
      s4_m_nxt = '0;
    end else if (mdiff > $signed({5'b0, MOIST_FULL})) begin
      s4_m_nxt = MOIST_FULL;
    end else begin
      s4_m_nxt = mdiff[9:0];
    end
    thresh = 11'({cfg.trigger_percent, 3'b000}) + 11'({cfg.trigger_percent, 1'b0});
    s4_valve_nxt = cfg.control_enabled && ({1'b0, s4_m_nxt} < thresh);

    sel_v = cfg.report_moisture ? 14'(s4_m_r) : s4_t_r;
    hmul  = 28'(sel_v) * 28'(RECIP_100);

    h100 = 14'({s5_h_r, 6'b0}) + 14'({s5_h_r, 5'b0}) + 14'({s5_h_r, 2'b0});
    vrem = s5_v_r - h100;
    if (vrem >= 14'd100) begin
      s6_h_nxt = s5_h_r + 7'd1;
      s6_r_nxt = 7'(vrem - 14'd100);
    end else begin
      s6_h_nxt = s5_h_r;
      s6_r_nxt = vrem[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_tprod_r <= 26'(in_data.temp_sample) * TEMP_SCALE;
      s1_mprod_r <= 23'(in_data.moisture_sample) * MOIST_SCALE;
      s1_wet_r   <= 23'(cfg.wet_offset_mv) * ADC_FULL;
      s1_wsum_r  <= 14'(cfg.wet_offset_mv) + 14'(cfg.span_mv);

      s2_tprod_r <= s1_tprod_r;
      s2_mx_r    <= mx;
      s2_tq_r    <= tmul[DIV_SHIFT +: 16];
      s2_mq_r    <= mmul[DIV_SHIFT +: 13];
      s2_wet_r   <= (s1_mprod_r <= s1_wet_r);
      s2_wsum_r  <= s1_wsum_r;

      s3_tq_r    <= s3_tq_nxt;
      s3_mq_r    <= s3_mq_nxt;
      s3_wet_r   <= s2_wet_r;
      s3_wsum_r  <= s2_wsum_r;

      s4_t_r     <= s4_t_nxt;
      s4_m_r     <= s4_m_nxt;
      s4_valve_r <= s4_valve_nxt;

      s5_v_r     <= sel_v;
      s5_h_r     <= hmul[HUND_SHIFT +: 7];
      s5_t_r     <= s4_t_r;
      s5_m_r     <= s4_m_r;
      s5_valve_r <= s4_valve_r;
      s5_rep_r   <= cfg.report_moisture;

      s6_h_r     <= s6_h_nxt;
      s6_r_r     <= s6_r_nxt;
      s6_t_r     <= s5_t_r;
      s6_m_r     <= s5_m_r;
      s6_valve_r <= s5_valve_r;
      s6_rep_r   <= s5_rep_r;

      s7_job_r.digits[3]    <= div10(s6_h_r);
      s7_job_r.digits[2]    <= mod10(s6_h_r);
      s7_job_r.digits[1]    <= div10(s6_r_r);
      s7_job_r.digits[0]    <= mod10(s6_r_r);
      s7_job_r.rep_moist    <= s6_rep_r;
      s7_job_r.valve        <= s6_valve_r;
      s7_job_r.temp_centi   <= s6_t_r;
      s7_job_r.moist_tenths <= s6_m_r;
    end
  end

  assign push.valid = vld_r[NST-1] && !q_full;
  assign push.job   = s7_job_r;

endmodule
`default_nettype wire

/* sv/smvr_queue.sv */
`default_nettype none
`include "soil_moisture_valve_reporter_macros.svh"
module smvr_queue import smvr_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire smvr_push_t push,
  output logic            full,
  input  wire logic       pop,
  output smvr_job_t       head,
  output logic            empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  smvr_job_t       mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push.valid && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (!push.valid && pop) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= wrap_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= wrap_inc(rd_ptr_r);
      end
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.job;
    end
  end

  `SMVR_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= CW'(DEPTH))
  `SMVR_ASSERT(a_no_push_full, clk, rst_n, !(push.valid && full))
  `SMVR_ASSERT(a_no_pop_empty, clk, rst_n, !(pop && empty))
  `SMVR_ASSERT_NEXT(a_cnt_up, clk, rst_n, push.valid && !pop, cnt_r == $past(cnt_r) + CW'(1))

endmodule
`default_nettype wire

/* sv/smvr_back.sv */
`default_nettype none
module smvr_back import smvr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire smvr_job_t head,
  input  wire logic      empty,
  output logic           pop,
  output logic           out_valid,
  input  wire logic      out_stall,
  output smvr_out_t      out_data
);

  logic [2:0]  pos_r, pos_nxt;
  logic        load;
  logic        out_valid_r;
  smvr_out_t   out_r, out_nxt;
  logic [7:0]  ch_d3, ch_d2, ch_d1, ch_d0;

  assign load = !empty && (!out_valid_r || !out_stall);
  assign pop  = load && (pos_r == POS_LF);
  assign pos_nxt = (pos_r == POS_LF) ? POS_D3 : pos_r + 3'd1;

  always_comb begin
    ch_d3 = ASCII_ZERO + 8'(head.digits[3]);
    ch_d2 = ASCII_ZERO + 8'(head.digits[2]);
    ch_d1 = ASCII_ZERO + 8'(head.digits[1]);
    ch_d0 = ASCII_ZERO + 8'(head.digits[0]);
    out_nxt.last_byte         = (pos_r == POS_LF);
    out_nxt.valve_open        = head.valve;
    out_nxt.temperature_centi = head.temp_centi;
    out_nxt.moisture_tenths   = head.moist_tenths;
    unique case (pos_r)
      POS_D3:   out_nxt.text_byte = ch_d3;
      POS_D2:   out_nxt.text_byte = ch_d2;
      POS_MIDA: out_nxt.text_byte = head.rep_moist ? ch_d1 : ASCII_POINT;
      POS_MIDB: out_nxt.text_byte = head.rep_moist ? ASCII_POINT : ch_d1;
      POS_D0:   out_nxt.text_byte = ch_d0;
      POS_CR:   out_nxt.text_byte = ASCII_CR;
      default:  out_nxt.text_byte = ASCII_LF;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_D3;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        pos_r <= pos_nxt;
      end
      if (!out_valid_r || !out_stall) begin
        out_valid_r <= !empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps
module testbench;
  import smvr_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned LONG_HOLD    = 80;
  localparam int unsigned REPORT_BYTES = 7;
  localparam logic [2:0]  CFG_IDX_UNUSED_LO = 3'd5;
  localparam logic [2:0]  CFG_IDX_UNUSED_HI = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  smvr_in_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  smvr_out_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [2:0]            cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  soil_moisture_valve_reporter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // predictor state
  smvr_cfg_t cal = '{control_enabled: RST_CONTROL_ENABLED,
                     report_moisture: RST_REPORT_MOISTURE,
                     trigger_percent: RST_TRIGGER_PERCENT,
                     wet_offset_mv:   RST_WET_OFFSET_MV,
                     span_mv:         RST_SPAN_MV};
  logic valve_state = 1'b0;

  smvr_in_t  pending_samples[$];
  smvr_out_t report_q[$];

  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;
  int unsigned samples_sent = 0;
  int unsigned bytes_seen = 0;
  int unsigned reg_writes = 0;
  int unsigned send_gap = 0;
  int unsigned stall_left = 0;
  int unsigned hold_count = 0;
  logic quiet = 1'b0;
  logic long_hold_go = 1'b0;
  logic long_hold_done = 1'b0;

  task automatic predict_report(input smvr_in_t s);
    int unsigned ts, ms, tc, mt, scaled, wet_scaled;
    int v;
    logic [7:0] txt [REPORT_BYTES];
    smvr_out_t r;
    ts = s.temp_sample;
    ms = s.moisture_sample;
    tc = ts * 50000 / 1023;
    if (tc > 9999) tc = 9999;
    scaled = ms * 5000;
    wet_scaled = int'(cal.wet_offset_mv) * 1023;
    if (scaled <= wet_scaled) begin
      mt = 1000;
    end else begin
      v = int'(cal.wet_offset_mv) + int'(cal.span_mv) - int'((scaled + 1022) / 1023);
      if (v < 0) v = 0;
      if (v > 1000) v = 1000;
      mt = v;
    end
    if (cal.report_moisture) begin
      txt[0] = ASCII_ZERO + 8'(mt / 1000);
      txt[1] = ASCII_ZERO + 8'((mt / 100) % 10);
      txt[2] = ASCII_ZERO + 8'((mt / 10) % 10);
      txt[3] = ASCII_POINT;
      txt[4] = ASCII_ZERO + 8'(mt % 10);
    end else begin
      txt[0] = ASCII_ZERO + 8'(tc / 1000);
      txt[1] = ASCII_ZERO + 8'((tc / 100) % 10);
      txt[2] = ASCII_POINT;
      txt[3] = ASCII_ZERO + 8'((tc / 10) % 10);
      txt[4] = ASCII_ZERO + 8'(tc % 10);
    end
    txt[5] = ASCII_CR;
    txt[6] = ASCII_LF;
    if (cal.control_enabled) valve_state = (mt < int'(cal.trigger_percent) * 10);
    else valve_state = 1'b0;
    for (int k = 0; k < REPORT_BYTES; k++) begin
      r.text_byte = txt[k];
      r.last_byte = (k == REPORT_BYTES - 1);
      r.valve_open = valve_state;
      r.temperature_centi = 14'(tc);
      r.moisture_tenths = 10'(mt);
      report_q.push_back(r);
    end
  endtask

  task automatic check_byte(input smvr_out_t got);
    smvr_out_t exp;
    if (report_q.size() == 0) begin
      $error("unexpected report byte %0d", got.text_byte);
      fail_count++;
    end else begin
      exp = report_q.pop_front();
      if (got.text_byte !== exp.text_byte) begin
        $error("text_byte: expected %0d, actual %0d", exp.text_byte, got.text_byte);
        fail_count++;
      end
      if (got.last_byte !== exp.last_byte) begin
        $error("last_byte: expected %0d, actual %0d", exp.last_byte, got.last_byte);
        fail_count++;
      end
      if (got.valve_open !== exp.valve_open) begin
        $error("valve_open: expected %0d, actual %0d", exp.valve_open, got.valve_open);
        fail_count++;
      end
      if (got.temperature_centi !== exp.temperature_centi) begin
        $error("temperature_centi: expected %0d, actual %0d",
               exp.temperature_centi, got.temperature_centi);
        fail_count++;
      end
      if (got.moisture_tenths !== exp.moisture_tenths) begin
        $error("moisture_tenths: expected %0d, actual %0d",
               exp.moisture_tenths, got.moisture_tenths);
        fail_count++;
      end
    end
  endtask

  // sample driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_report(in_data);
        samples_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          in_valid <= 1'b1;
          in_data <= pending_samples.pop_front();
          if (!quiet && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 11);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // report monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        check_byte(out_data);
        bytes_seen++;
      end
      if (long_hold_go && !long_hold_done) begin
        out_stall <= 1'b1;
        hold_count <= hold_count + 1;
        if (hold_count == LONG_HOLD - 1) long_hold_done <= 1'b1;
      end else if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(0, 10);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** soil_moisture_valve_reporter: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input int unsigned val);
    logic [CFG_DATA_W-1:0] v;
    v = CFG_DATA_W'(val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CONTROL_ENABLED: begin
        cal.control_enabled = v[0];
        if (!v[0]) valve_state = 1'b0;
      end
      CFG_REPORT_MOISTURE: cal.report_moisture = v[0];
      CFG_TRIGGER_PERCENT: cal.trigger_percent = v[6:0];
      CFG_WET_OFFSET_MV:   cal.wet_offset_mv = v;
      CFG_SPAN_MV:         cal.span_mv = v;
      default: ;
    endcase
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic add_sample(input int unsigned t, input int unsigned m);
    smvr_in_t s;
    s.temp_sample = 10'(t);
    s.moisture_sample = 10'(m);
    pending_samples.push_back(s);
  endtask

  task automatic settle();
    while (pending_samples.size() != 0 || in_valid || report_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic randomize_config();
    int unsigned trig;
    write_reg(CFG_CONTROL_ENABLED, $urandom_range(0, 8191));
    write_reg(CFG_REPORT_MOISTURE, $urandom_range(0, 8191));
    case ($urandom_range(0, 5))
      0: trig = 0;
      1: trig = 100;
      2: trig = 127;
      default: trig = $urandom_range(0, 100);
    endcase
    write_reg(CFG_TRIGGER_PERCENT, trig);
    write_reg(CFG_WET_OFFSET_MV, ($urandom_range(0, 7) == 0) ? 8191 : $urandom_range(0, 5000));
    write_reg(CFG_SPAN_MV, ($urandom_range(0, 7) == 0) ? 8191 : $urandom_range(0, 5000));
  endtask

  // moisture is biased toward the active part of the scale
  task automatic queue_random_samples(input int unsigned n);
    int unsigned lo_mark, hi_mark, t, m;
    for (int i = 0; i < n; i++) begin
      lo_mark = int'(cal.wet_offset_mv) * 1023 / 5000;
      hi_mark = (int'(cal.wet_offset_mv) + int'(cal.span_mv)) * 1023 / 5000 + 4;
      if (lo_mark > 1023) lo_mark = 1023;
      if (hi_mark > 1023) hi_mark = 1023;
      t = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 210) : $urandom_range(0, 1023);
      if ($urandom_range(0, 1) == 0) m = $urandom_range(0, 1023);
      else m = $urandom_range(lo_mark, hi_mark);
      add_sample(t, m);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults: temperature text, saturation edge, wet edge
    add_sample(0, 0);
    add_sample(1023, 1023);
    add_sample(204, 262);
    add_sample(205, 263);
    add_sample(1, 1);
    add_sample(1022, 500);
    add_sample(682, 341);
    settle();

    write_reg(CFG_REPORT_MOISTURE, 1);
    add_sample(10, 262);
    add_sample(20, 263);
    add_sample(30, 1023);
    add_sample(40, 0);
    add_sample(50, 700);
    settle();

    // zero calibration, trigger past 100 via an oversized value, control off via a wide value
    write_reg(CFG_WET_OFFSET_MV, 0);
    write_reg(CFG_SPAN_MV, 0);
    write_reg(CFG_TRIGGER_PERCENT, 8191);
    add_sample(100, 0);
    add_sample(100, 1);
    settle();
    write_reg(CFG_CONTROL_ENABLED, 2);
    add_sample(300, 1);
    settle();

    write_reg(CFG_CONTROL_ENABLED, 1);
    write_reg(CFG_WET_OFFSET_MV, 8191);
    write_reg(CFG_SPAN_MV, 8191);
    write_reg(CFG_TRIGGER_PERCENT, 100);
    write_reg(CFG_IDX_UNUSED_LO, 0);
    write_reg(CFG_IDX_UNUSED_HI, 8191);
    add_sample(512, 1023);
    add_sample(1023, 0);
    settle();

    write_reg(CFG_WET_OFFSET_MV, 50);
    write_reg(CFG_SPAN_MV, 5000);
    write_reg(CFG_TRIGGER_PERCENT, 0);
    add_sample(77, 11);
    add_sample(777, 1023);
    settle();

    randomize_config();
    queue_random_samples(30);
    settle();

    // receiver holds off while requests keep coming
    randomize_config();
    long_hold_go <= 1'b1;
    queue_random_samples(30);
    settle();

    randomize_config();
    queue_random_samples(15);
    settle();
    queue_random_samples(15);
    settle();

    randomize_config();
    queue_random_samples(10);
    settle();

    quiet <= 1'b1;
    randomize_config();
    queue_random_samples(15);
    settle();

    $display("Checked %0d sample pairs (%0d report bytes) across %0d register writes,",
             samples_sent, bytes_seen, reg_writes);
    $display("covering saturation, clamping, calibration extremes and back-pressure.");
    if (fail_count == 0) begin
      $display("** soil_moisture_valve_reporter: PASSED **");
    end else begin
      $display("** soil_moisture_valve_reporter: FAILED **");
    end
    $finish;
  end

endmodule
